/* sv/rfci_pkg.sv */
package rfci_pkg;

  localparam logic [7:0] DEFAULT_HEADER_LEN = 8'd26;

  localparam logic [7:0] CH_ESC   = 8'h1B;
  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_C     = 8'h63;
  localparam logic [7:0] CH_E     = 8'h45;
  localparam logic [7:0] CH_PAREN = 8'h28;
  localparam logic [7:0] CH_S     = 8'h73;
  localparam logic [7:0] CH_W     = 8'h57;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  localparam logic KIND_RECORD = 1'b0;
  localparam logic KIND_ERROR  = 1'b1;

endpackage

/* sv/rfci_if.sv */
interface rfci_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       is_last;

  modport source (output valid, output data_byte, output is_last, input ready);
  modport sink   (input valid, input data_byte, input is_last, output ready);
endinterface

interface rfci_rec_if #(
  parameter int unsigned ADDR_BITS = 20,
  parameter int unsigned LEN_BITS  = 16
);
  logic                 valid;
  logic                 ready;
  logic                 kind;
  logic [7:0]           char_code;
  logic [ADDR_BITS-1:0] record_offset;
  logic [LEN_BITS-1:0]  data_length;

  modport source (output valid, output kind, output char_code, output record_offset,
                  output data_length, input ready);
  modport sink   (input valid, input kind, input char_code, input record_offset,
                  input data_length, output ready);
endinterface

/* sv/raster_font_char_indexer.sv */
// Parses a raster font file presented one byte per word, skipping header_len bytes
// and then reporting each character record header (code, offset of its leading
// escape, data length) or the first format error of the file. One byte is taken
// every cycle while the result register has room; a byte passes the input register
// and the parse logic, and its result is loaded into the result register as the byte
// leaves the input register, where the sink can take it. The only stall comes from a
// full result register that the sink is not taking.
module raster_font_char_indexer #(
  parameter int unsigned FILE_ADDR_BITS = 20,
  parameter int unsigned LENGTH_BITS    = 16
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  rfci_byte_if.sink         byte_i,
  rfci_rec_if.source        rec_o,
  input  logic              cfg_we_i,
  input  logic [7:0]        cfg_wdata_i
);
  import rfci_pkg::*;

  localparam int unsigned PayW = 1 + 8 + FILE_ADDR_BITS + LENGTH_BITS;

  logic [7:0]                header_len_q;
  logic                      in_valid, in_last, take, out_space, res_valid;
  logic [7:0]                in_data;
  logic                      res_kind;
  logic [7:0]                res_code;
  logic [FILE_ADDR_BITS-1:0] res_offset;
  logic [LENGTH_BITS-1:0]    res_length;
  logic [PayW-1:0]           res_pay, out_pay;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      header_len_q <= DEFAULT_HEADER_LEN;
    end else if (cfg_we_i) begin
      header_len_q <= cfg_wdata_i;
    end
  end

  assign take = in_valid && out_space;

  rfci_in_stage u_in (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (byte_i.valid),
    .ready_o (byte_i.ready),
    .data_i  (byte_i.data_byte),
    .last_i  (byte_i.is_last),
    .take_i  (take),
    .valid_o (in_valid),
    .data_o  (in_data),
    .last_o  (in_last)
  );

  rfci_parser #(
    .ADDR_BITS (FILE_ADDR_BITS),
    .LEN_BITS  (LENGTH_BITS)
  ) u_parser (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .header_len_i    (header_len_q),
    .take_i          (take),
    .data_i          (in_data),
    .last_i          (in_last),
    .res_valid_o     (res_valid),
    .kind_o          (res_kind),
    .char_code_o     (res_code),
    .record_offset_o (res_offset),
    .data_length_o   (res_length)
  );

  assign res_pay = {res_kind, res_code, res_offset, res_length};

  rfci_out_stage #(
    .WIDTH (PayW)
  ) u_out (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .load_i  (take && res_valid),
    .data_i  (res_pay),
    .space_o (out_space),
    .valid_o (rec_o.valid),
    .ready_i (rec_o.ready),
    .data_o  (out_pay)
  );

  assign rec_o.kind          = out_pay[PayW-1];
  assign rec_o.char_code     = out_pay[PayW-2 -: 8];
  assign rec_o.record_offset = out_pay[LENGTH_BITS +: FILE_ADDR_BITS];
  assign rec_o.data_length   = out_pay[LENGTH_BITS-1:0];

endmodule

/* sv/rfci_in_stage.sv */
module rfci_in_stage (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       valid_i,
  output logic       ready_o,
  input  logic [7:0] data_i,
  input  logic       last_i,
  input  logic       take_i,
  output logic       valid_o,
  output logic [7:0] data_o,
  output logic       last_o
);

  logic       valid_q;
  logic [7:0] data_q;
  logic       last_q;

  // A new word may enter when the stage is empty or the held one leaves in the same cycle.
  assign ready_o = !valid_q || take_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      data_q <= data_i;
      last_q <= last_i;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;
  assign last_o  = last_q;

endmodule

/* sv/rfci_parser.sv */
module rfci_parser #(
  parameter int unsigned ADDR_BITS = 20,
  parameter int unsigned LEN_BITS  = 16
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic [7:0]           header_len_i,
  input  logic                 take_i,
  input  logic [7:0]           data_i,
  input  logic                 last_i,
  output logic                 res_valid_o,
  output logic                 kind_o,
  output logic [7:0]           char_code_o,
  output logic [ADDR_BITS-1:0] record_offset_o,
  output logic [LEN_BITS-1:0]  data_length_o
);
  import rfci_pkg::*;

  typedef enum logic [3:0] {
    PH_HEADER, PH_ESC1, PH_STAR, PH_C, PH_CODE0, PH_CODE,
    PH_ESC2, PH_PAREN, PH_S, PH_LEN0, PH_LEN, PH_DATA
  } phase_e;

  phase_e               phase_q, phase_d, phase_cur;
  logic [ADDR_BITS-1:0] pos_q, pos_d;
  logic [ADDR_BITS-1:0] start_q, start_d;
  logic [7:0]           code_q, code_d;
  logic [LEN_BITS-1:0]  len_q, len_d;
  logic [LEN_BITS-1:0]  skip_q, skip_d, skip_dec;
  logic                 err_q, err_d;

  logic                 is_digit;
  logic [3:0]           digit;
  logic [11:0]          code_ext, code_v;
  logic [LEN_BITS+3:0]  len_ext, len_v;
  logic                 code_ovf, len_ovf;
  logic                 bad, found, open_header;

  assign is_digit = (data_i >= CH_ZERO) && (data_i <= CH_NINE);
  assign digit    = 4'(data_i - CH_ZERO);

  // Multiply by ten as two shifts and an add; the extra top bits catch overflow.
  assign code_ext = 12'(code_q);
  assign code_v   = (code_ext << 3) + (code_ext << 1) + 12'(digit);
  assign code_ovf = (code_v > 12'd255);

  assign len_ext  = (LEN_BITS+4)'(len_q);
  assign len_v    = (len_ext << 3) + (len_ext << 1) + (LEN_BITS+4)'(digit);
  assign len_ovf  = (len_v[LEN_BITS+3:LEN_BITS] != 4'd0);

  assign skip_dec = (skip_q != '0) ? skip_q - 1'b1 : '0;

  always_comb begin
    phase_cur = phase_q;
    if (phase_q == PH_HEADER && pos_q >= ADDR_BITS'(header_len_i)) begin
      phase_cur = PH_ESC1;
    end
    phase_d = phase_cur;
    start_d = start_q;
    code_d  = code_q;
    len_d   = len_q;
    skip_d  = skip_q;
    bad     = 1'b0;
    found   = 1'b0;
    if (!err_q) begin
      case (phase_cur)
        PH_HEADER: begin
        end
        PH_ESC1: begin
          if (data_i == CH_ESC) begin
            start_d = pos_q;
            phase_d = PH_STAR;
          end else begin
            bad = 1'b1;
          end
        end
        PH_STAR: begin
          if (data_i == CH_STAR) phase_d = PH_C; else bad = 1'b1;
        end
        PH_C: begin
          if (data_i == CH_C) begin
            code_d  = '0;
            phase_d = PH_CODE0;
          end else begin
            bad = 1'b1;
          end
        end
        PH_CODE0, PH_CODE: begin
          if (is_digit) begin
            if (code_ovf) begin
              bad = 1'b1;
            end else begin
              code_d  = code_v[7:0];
              phase_d = PH_CODE;
            end
          end else if (data_i == CH_E && phase_cur == PH_CODE) begin
            phase_d = PH_ESC2;
          end else begin
            bad = 1'b1;
          end
        end
        PH_ESC2: begin
          if (data_i == CH_ESC) phase_d = PH_PAREN; else bad = 1'b1;
        end
        PH_PAREN: begin
          if (data_i == CH_PAREN) phase_d = PH_S; else bad = 1'b1;
        end
        PH_S: begin
          if (data_i == CH_S) begin
            len_d   = '0;
            phase_d = PH_LEN0;
          end else begin
            bad = 1'b1;
          end
        end
        PH_LEN0, PH_LEN: begin
          if (is_digit) begin
            if (len_ovf) begin
              bad = 1'b1;
            end else begin
              len_d   = len_v[LEN_BITS-1:0];
              phase_d = PH_LEN;
            end
          end else if (data_i == CH_W && phase_cur == PH_LEN) begin
            found   = 1'b1;
            skip_d  = len_q;
            phase_d = (len_q == '0) ? PH_ESC1 : PH_DATA;
          end else begin
            bad = 1'b1;
          end
        end
        PH_DATA: begin
          skip_d = skip_dec;
          if (skip_dec == '0) phase_d = PH_ESC1;
        end
        default: begin
          bad = 1'b1;
        end
      endcase
      open_header = (phase_d != PH_HEADER) && (phase_d != PH_ESC1) && (phase_d != PH_DATA);
      // The file may not end part-way through a record header.
      if (!bad && !found && last_i && open_header) begin
        bad = 1'b1;
      end
    end else begin
      open_header = 1'b0;
    end
    err_d = err_q || bad;
    pos_d = pos_q + 1'b1;
    if (last_i) begin
      phase_d = PH_HEADER;
      pos_d   = '0;
      start_d = '0;
      code_d  = '0;
      len_d   = '0;
      skip_d  = '0;
      err_d   = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_HEADER;
      pos_q   <= '0;
      start_q <= '0;
      code_q  <= '0;
      len_q   <= '0;
      skip_q  <= '0;
      err_q   <= 1'b0;
    end else if (take_i) begin
      phase_q <= phase_d;
      pos_q   <= pos_d;
      start_q <= start_d;
      code_q  <= code_d;
      len_q   <= len_d;
      skip_q  <= skip_d;
      err_q   <= err_d;
    end
  end

  assign res_valid_o     = bad || found;
  assign kind_o          = bad ? KIND_ERROR : KIND_RECORD;
  assign char_code_o     = bad ? 8'd0 : code_q;
  assign record_offset_o = bad ? pos_q : start_q;
  assign data_length_o   = bad ? '0 : len_q;

endmodule

/* sv/rfci_out_stage.sv */
module rfci_out_stage #(
  parameter int unsigned WIDTH = 45
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             load_i,
  input  logic [WIDTH-1:0] data_i,
  output logic             space_o,
  output logic             valid_o,
  input  logic             ready_i,
  output logic [WIDTH-1:0] data_o
);

  logic             valid_q;
  logic [WIDTH-1:0] data_q;

  // Room for a new result when empty or when the held word is taken now.
  assign space_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (space_o) begin
      valid_q <= load_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (space_o && load_i) begin
      data_q <= data_i;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

/* sv/rfci_checker.sv */
module rfci_checker #(
  parameter int unsigned ADDR_BITS = 20,
  parameter int unsigned LEN_BITS  = 16
) (
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 in_valid_i,
  input logic                 in_ready_i,
  input logic                 out_valid_i,
  input logic                 out_ready_i,
  input logic                 out_kind_i,
  input logic [7:0]           out_code_i,
  input logic [ADDR_BITS-1:0] out_offset_i,
  input logic [LEN_BITS-1:0]  out_length_i
);
  import rfci_pkg::*;

  // A held result word must stay valid and keep its offset until it is taken.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_offset_i))
    else $error("result word dropped or changed while stalled");

  // An error word carries no code and no length.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_kind_i == KIND_ERROR |-> out_code_i == 8'd0 && out_length_i == '0)
    else $error("error word with non-zero code or length");

  // Input is refused only while a finished result waits on a stalled sink.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_i |-> out_valid_i && !out_ready_i)
    else $error("input refused without output backpressure");

  // A result appearing from empty comes from a byte accepted through the input register.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_i) |-> $past(in_valid_i && in_ready_i, 2))
    else $error("result appeared without a matching input byte");

endmodule

bind raster_font_char_indexer rfci_checker #(
  .ADDR_BITS (FILE_ADDR_BITS),
  .LEN_BITS  (LENGTH_BITS)
) u_rfci_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (byte_i.valid),
  .in_ready_i   (byte_i.ready),
  .out_valid_i  (rec_o.valid),
  .out_ready_i  (rec_o.ready),
  .out_kind_i   (rec_o.kind),
  .out_code_i   (rec_o.char_code),
  .out_offset_i (rec_o.record_offset),
  .out_length_i (rec_o.data_length)
);

/* test/font_record_checker.sv */
`timescale 1ns / 100ps

module font_record_checker (
  input  logic       clk_i,
  input  logic       rst_ni,
  rfci_byte_if       byte_mon,
  rfci_rec_if        rec_mon,
  input  logic       cfg_we_i,
  input  logic [7:0] cfg_wdata_i,
  output int         error_count_o,
  output int         pending_o,
  output int         parsed_o
);
  import rfci_pkg::*;

  typedef enum logic [3:0] {
    SCAN_HEADER,
    SCAN_ESC_A,
    SCAN_STAR,
    SCAN_LOWER_C,
    SCAN_CODE_FIRST,
    SCAN_CODE_MORE,
    SCAN_ESC_B,
    SCAN_PAREN,
    SCAN_LOWER_S,
    SCAN_LEN_FIRST,
    SCAN_LEN_MORE,
    SCAN_DATA
  } scan_state_e;

  typedef struct packed {
    logic        kind;
    logic [7:0]  char_code;
    logic [19:0] record_offset;
    logic [15:0] data_length;
  } font_record_t;

  font_record_t expected_records[$];

  logic [7:0]  hdr_len;
  scan_state_e scan;
  logic [19:0] file_pos;
  logic [19:0] rec_start;
  logic [7:0]  code_acc;
  logic [15:0] len_acc;
  logic [15:0] skip_left;
  logic        err_seen;

  task automatic clear_file_state();
    scan      = SCAN_HEADER;
    file_pos  = '0;
    rec_start = '0;
    code_acc  = '0;
    len_acc   = '0;
    skip_left = '0;
    err_seen  = 1'b0;
  endtask

  // Advances the parse by one file byte and queues the record or error it causes.
  task automatic index_font_byte(input logic [7:0] b, input logic last);
    logic [19:0]  pos;
    int unsigned  acc;
    logic         bad;
    logic         found;
    logic         is_digit;
    pos      = file_pos;
    bad      = 1'b0;
    found    = 1'b0;
    is_digit = (b >= CH_ZERO) && (b <= CH_NINE);
    parsed_o++;
    if (!err_seen) begin
      if (scan == SCAN_HEADER && pos >= 20'(hdr_len)) scan = SCAN_ESC_A;
      case (scan)
        SCAN_HEADER: ;
        SCAN_ESC_A: begin
          if (b == CH_ESC) begin
            rec_start = pos;
            scan      = SCAN_STAR;
          end else bad = 1'b1;
        end
        SCAN_STAR: begin
          if (b == CH_STAR) scan = SCAN_LOWER_C; else bad = 1'b1;
        end
        SCAN_LOWER_C: begin
          if (b == CH_C) begin
            code_acc = '0;
            scan     = SCAN_CODE_FIRST;
          end else bad = 1'b1;
        end
        SCAN_CODE_FIRST, SCAN_CODE_MORE: begin
          if (is_digit) begin
            acc = 32'(code_acc) * 10 + 32'(b - CH_ZERO);
            if (acc > 255) bad = 1'b1;
            else begin
              code_acc = acc[7:0];
              scan     = SCAN_CODE_MORE;
            end
          end else if (b == CH_E && scan == SCAN_CODE_MORE) begin
            scan = SCAN_ESC_B;
          end else bad = 1'b1;
        end
        SCAN_ESC_B: begin
          if (b == CH_ESC) scan = SCAN_PAREN; else bad = 1'b1;
        end
        SCAN_PAREN: begin
          if (b == CH_PAREN) scan = SCAN_LOWER_S; else bad = 1'b1;
        end
        SCAN_LOWER_S: begin
          if (b == CH_S) begin
            len_acc = '0;
            scan    = SCAN_LEN_FIRST;
          end else bad = 1'b1;
        end
        SCAN_LEN_FIRST, SCAN_LEN_MORE: begin
          if (is_digit) begin
            acc = 32'(len_acc) * 10 + 32'(b - CH_ZERO);
            if (acc > 32'hFFFF) bad = 1'b1;
            else begin
              len_acc = acc[15:0];
              scan    = SCAN_LEN_MORE;
            end
          end else if (b == CH_W && scan == SCAN_LEN_MORE) begin
            found     = 1'b1;
            skip_left = len_acc;
            scan      = (len_acc == 0) ? SCAN_ESC_A : SCAN_DATA;
          end else bad = 1'b1;
        end
        SCAN_DATA: begin
          if (skip_left != 0) skip_left--;
          if (skip_left == 0) scan = SCAN_ESC_A;
        end
        default: bad = 1'b1;
      endcase
      // A file may end in the font header, between records or in data, but not
      // part-way through a record header.
      if (!bad && !found && last && scan != SCAN_HEADER && scan != SCAN_ESC_A &&
          scan != SCAN_DATA)
        bad = 1'b1;
    end

    if (bad) begin
      err_seen = 1'b1;
      expected_records.push_back('{KIND_ERROR, 8'd0, pos, 16'd0});
    end else if (found) begin
      expected_records.push_back('{KIND_RECORD, code_acc, rec_start, len_acc});
    end

    file_pos = pos + 20'd1;
    if (last) clear_file_state();
  endtask

  task automatic compare_record(input font_record_t got);
    font_record_t want;
    if (expected_records.size() == 0) begin
      $error("record word with nothing predicted: kind %0d offset %0d", got.kind,
             got.record_offset);
      error_count_o++;
    end else begin
      want = expected_records.pop_front();
      if (got.kind !== want.kind) begin
        $error("kind: expected %0d, got %0d", want.kind, got.kind);
        error_count_o++;
      end
      if (got.char_code !== want.char_code) begin
        $error("char_code: expected %0d, got %0d", want.char_code, got.char_code);
        error_count_o++;
      end
      if (got.record_offset !== want.record_offset) begin
        $error("record_offset: expected %0d, got %0d", want.record_offset,
               got.record_offset);
        error_count_o++;
      end
      if (got.data_length !== want.data_length) begin
        $error("data_length: expected %0d, got %0d", want.data_length, got.data_length);
        error_count_o++;
      end
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hdr_len = DEFAULT_HEADER_LEN;
      clear_file_state();
      expected_records.delete();
      error_count_o = 0;
      pending_o     = 0;
      parsed_o      = 0;
    end else begin
      if (cfg_we_i) hdr_len = cfg_wdata_i;
      if (byte_mon.valid && byte_mon.ready)
        index_font_byte(byte_mon.data_byte, byte_mon.is_last);
      if (rec_mon.valid && rec_mon.ready)
        compare_record({rec_mon.kind, rec_mon.char_code, rec_mon.record_offset,
                        rec_mon.data_length});
      pending_o = expected_records.size();
    end
  end

endmodule

/* test/tb_raster_font_char_indexer.sv */
`timescale 1ns / 100ps

module tb_raster_font_char_indexer;
  import rfci_pkg::*;

  localparam int unsigned ADDR_BITS     = 20;
  localparam int unsigned LEN_BITS      = 16;
  localparam int unsigned PARSED_GOAL   = 1700;
  localparam int unsigned CYCLE_LIMIT   = 400000;
  localparam int unsigned SETTLE_CYCLES = 6;
  localparam int unsigned IDLE_PERCENT  = 23;

  typedef enum int {
    FAULT_NONE,
    FAULT_BAD_BYTE,
    FAULT_CODE_OVERFLOW,
    FAULT_LEN_OVERFLOW,
    FAULT_NO_DIGITS,
    FAULT_CUT_HEADER
  } record_fault_e;

  logic       clk_i     = 1'b0;
  logic       rst_ni    = 1'b0;
  logic       cfg_we    = 1'b0;
  logic [7:0] cfg_wdata = 8'd0;
  bit         steady    = 1'b0;
  int         cycle_count = 0;
  int         mismatch_count;
  int         pending_records;
  int         parsed_bytes;
  logic [7:0] file_bytes[$];

  rfci_byte_if byte_bus ();
  rfci_rec_if #(.ADDR_BITS(ADDR_BITS), .LEN_BITS(LEN_BITS)) rec_bus ();

  raster_font_char_indexer #(
    .FILE_ADDR_BITS(ADDR_BITS),
    .LENGTH_BITS   (LEN_BITS)
  ) uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .byte_i     (byte_bus),
    .rec_o      (rec_bus),
    .cfg_we_i   (cfg_we),
    .cfg_wdata_i(cfg_wdata)
  );

  font_record_checker record_check (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .byte_mon     (byte_bus),
    .rec_mon      (rec_bus),
    .cfg_we_i     (cfg_we),
    .cfg_wdata_i  (cfg_wdata),
    .error_count_o(mismatch_count),
    .pending_o    (pending_records),
    .parsed_o     (parsed_bytes)
  );

  always #6 clk_i = ~clk_i;

  always @(negedge clk_i) begin
    rec_bus.ready <= steady || ($urandom_range(0, 99) >= IDLE_PERCENT);
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  task automatic send_byte(input logic [7:0] b, input logic last);
    @(negedge clk_i);
    while (!steady && $urandom_range(0, 99) < IDLE_PERCENT) begin
      byte_bus.valid <= 1'b0;
      @(negedge clk_i);
    end
    byte_bus.valid     <= 1'b1;
    byte_bus.data_byte <= b;
    byte_bus.is_last   <= last;
    @(posedge clk_i);
    while (!byte_bus.ready) @(posedge clk_i);
  endtask

  // Holds the input idle until every predicted word has arrived, then lets the
  // pipeline settle as well before returning.
  task automatic drain_records();
    @(negedge clk_i);
    byte_bus.valid <= 1'b0;
    while (pending_records != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  task automatic write_header_length(input logic [7:0] value);
    drain_records();
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(negedge clk_i);
    cfg_we    <= 1'b0;
  endtask

  task automatic send_text(input string text);
    for (int k = 0; k < text.len(); k++) send_byte(text[k], k == text.len() - 1);
  endtask

  task automatic send_file(input int pause_at, input int new_hdr);
    for (int i = 0; i < file_bytes.size(); i++) begin
      if (i == pause_at) begin
        if (new_hdr >= 0) write_header_length(new_hdr[7:0]);
        else drain_records();
      end
      send_byte(file_bytes[i], i == file_bytes.size() - 1);
    end
  endtask

  task automatic push_number(input int unsigned value);
    string digits;
    repeat (($urandom_range(0, 3) == 0) ? $urandom_range(1, 2) : 0)
      file_bytes.push_back(CH_ZERO);
    digits = $sformatf("%0d", value);
    for (int k = 0; k < digits.len(); k++) file_bytes.push_back(digits[k]);
  endtask

  // Appends one record header and its data; stop tells the caller the file is over.
  task automatic push_record(input record_fault_e fault, output bit stop);
    int unsigned code;
    int unsigned len;
    int unsigned n_data;
    int          start;
    int          keep;
    bit          drop_code;
    start     = file_bytes.size();
    stop      = 1'b0;
    drop_code = $urandom_range(0, 1);
    if ($urandom_range(0, 9) == 0) code = $urandom_range(0, 1) ? 255 : 0;
    else code = $urandom_range(0, 255);
    case ($urandom_range(0, 9))
      0:       len = $urandom_range(1000, 65535);
      1, 2:    len = $urandom_range(7, 40);
      default: len = $urandom_range(0, 6);
    endcase
    if (fault == FAULT_CODE_OVERFLOW) code = $urandom_range(256, 2000);
    if (fault == FAULT_LEN_OVERFLOW) len = $urandom_range(65536, 200000);

    file_bytes.push_back(CH_ESC);
    file_bytes.push_back(CH_STAR);
    file_bytes.push_back(CH_C);
    if (!(fault == FAULT_NO_DIGITS && drop_code)) push_number(code);
    file_bytes.push_back(CH_E);
    file_bytes.push_back(CH_ESC);
    file_bytes.push_back(CH_PAREN);
    file_bytes.push_back(CH_S);
    if (!(fault == FAULT_NO_DIGITS && !drop_code)) push_number(len);
    file_bytes.push_back(CH_W);

    if (fault == FAULT_BAD_BYTE)
      file_bytes[$urandom_range(start, file_bytes.size() - 1)] = 8'($urandom);

    if (fault == FAULT_CUT_HEADER) begin
      keep = $urandom_range(start + 1, file_bytes.size() - 1);
      while (file_bytes.size() > keep) void'(file_bytes.pop_back());
      stop = 1'b1;
    end else if (fault != FAULT_NONE) begin
      // After an error the rest of the file is ignored, so add a little noise.
      repeat ($urandom_range(0, 4)) file_bytes.push_back(8'($urandom));
      stop = 1'b1;
    end else begin
      // Huge records are cut short, which ends the file inside the data.
      n_data = (len > 40) ? $urandom_range(0, 8) : len;
      repeat (n_data) file_bytes.push_back(8'($urandom));
      stop = (len > 40);
    end
  endtask

  task automatic build_font_file(input int hdr_bytes, input int n_records);
    bit            stop;
    record_fault_e fault;
    int            keep;
    file_bytes.delete();
    repeat (hdr_bytes) file_bytes.push_back(8'($urandom));
    stop = 1'b0;
    for (int r = 0; r < n_records && !stop; r++) begin
      if ($urandom_range(0, 99) < 12) fault = record_fault_e'($urandom_range(1, 5));
      else fault = FAULT_NONE;
      push_record(fault, stop);
    end
    if ($urandom_range(0, 99) < 10 && file_bytes.size() > 1) begin
      keep = $urandom_range(1, file_bytes.size() - 1);
      while (file_bytes.size() > keep) void'(file_bytes.pop_back());
    end
    if (file_bytes.size() == 0) file_bytes.push_back(8'($urandom));
  endtask

  initial begin
    int hdr;
    int files;
    int pause_at;
    int h;
    int new_hdr;
    int phase;
    byte_bus.valid     = 1'b0;
    byte_bus.data_byte = 8'd0;
    byte_bus.is_last   = 1'b0;
    rec_bus.ready      = 1'b0;

    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // A short file that never leaves the default font header.
    send_text("abc");
    write_header_length(8'd0);
    // Widest code and length, the file then ends inside the data.
    send_text("\033*c255E\033(s65535W\377");
    // Leading zeros, zero code and length, the last byte completes the header.
    send_text("\033*c000E\033(s0W");
    // Code overflow, then the rest of the file is ignored.
    send_text("\033*c256E!");
    // Length overflow on its last digit, so the final byte is ignored.
    send_text("\033*c7E\033(s65536W");
    // File ends inside a record header.
    send_text("\033*");
    // A number without digits.
    send_text("\033*cE");
    // Mismatch on the very first byte.
    send_text("\200");

    phase = 0;
    while (parsed_bytes < PARSED_GOAL) begin
      steady = (phase == 3);
      if (phase % 4 == 2) begin
        // The header length is changed part-way through a file.
        h = $urandom_range(0, 20);
        write_header_length(8'(h + $urandom_range(1, 40)));
        build_font_file(h, $urandom_range(1, 3));
        pause_at = $urandom_range(0, h);
        new_hdr  = (pause_at == h) ? $urandom_range(0, h) : h;
        send_file(pause_at, new_hdr);
      end else begin
        if (phase == 1) hdr = 255;
        else if (phase == 5) hdr = 26;
        else hdr = $urandom_range(0, 8);
        write_header_length(8'(hdr));
        if (phase == 3) files = 12;
        else if (hdr == 255) files = 1;
        else files = $urandom_range(2, 5);
        repeat (files) begin
          if ($urandom_range(0, 99) < 8) begin
            file_bytes.delete();
            repeat ($urandom_range(1, 12))
              file_bytes.push_back(($urandom_range(0, 3) == 0) ? CH_ESC : 8'($urandom));
          end else begin
            build_font_file(hdr, $urandom_range(1, 5));
          end
          pause_at = ($urandom_range(0, 9) == 0) ? $urandom_range(0, file_bytes.size() - 1)
                                                 : -1;
          send_file(pause_at, -1);
        end
      end
      phase++;
    end

    drain_records();
    repeat (4) @(negedge clk_i);
    if (pending_records != 0) $error("%0d predicted words never arrived", pending_records);
    if (mismatch_count == 0 && pending_records == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
